### hw/rtl/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, constants and the Morse code table for the timing decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

	localparam int MAX_SYMBOLS = 5;
	localparam int SYM_W       = MAX_SYMBOLS;
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 2);
	localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
	localparam int STAMP_W     = 16;
	localparam int WRAP_W      = 8;
	localparam int TICK_W      = 24;
	localparam int REG_IDX_W   = 3;
	localparam int KIND_W      = 2;
	localparam int ASCII_W     = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [REG_IDX_W-1:0] REG_DOT_MIN  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DOT_MAX  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DASH_MIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DASH_MAX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAP_MIN  = 3'd4;

	localparam logic [TICK_W-1:0] DOT_MIN_RST  = 24'd469;
	localparam logic [TICK_W-1:0] DOT_MAX_RST  = 24'd3125;
	localparam logic [TICK_W-1:0] DASH_MIN_RST = 24'd3125;
	localparam logic [TICK_W-1:0] DASH_MAX_RST = 24'd6250;
	localparam logic [TICK_W-1:0] GAP_MIN_RST  = 24'd12500;

	localparam logic [KIND_W-1:0] KIND_DOT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DASH  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPACE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd3;

	localparam logic [ASCII_W-1:0] ASCII_DOT   = 7'h2E;
	localparam logic [ASCII_W-1:0] ASCII_DASH  = 7'h2D;
	localparam logic [ASCII_W-1:0] ASCII_SPACE = 7'h20;
	localparam logic [ASCII_W-1:0] ASCII_NONE  = 7'h00;

	localparam logic [1:0] CMD_DOT  = 2'd0;
	localparam logic [1:0] CMD_DASH = 2'd1;
	localparam logic [1:0] CMD_GAP  = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CNT_W-1:0] cnt;
		logic [SYM_W-1:0] bits;
	} mtd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mtd_qstat_t;

	function automatic logic [ASCII_W-1:0] mtd_lookup(input logic [CNT_W-1:0] cnt,
			input logic [SYM_W-1:0] bits);
		logic [ASCII_W-1:0] ch;
		ch = ASCII_NONE;
		case ({cnt, bits})
			{CNT_W'(2), SYM_W'(2)}:  ch = 7'h41;
			{CNT_W'(4), SYM_W'(1)}:  ch = 7'h42;
			{CNT_W'(4), SYM_W'(5)}:  ch = 7'h43;
			{CNT_W'(3), SYM_W'(1)}:  ch = 7'h44;
			{CNT_W'(1), SYM_W'(0)}:  ch = 7'h45;
			{CNT_W'(4), SYM_W'(4)}:  ch = 7'h46;
			{CNT_W'(3), SYM_W'(3)}:  ch = 7'h47;
			{CNT_W'(4), SYM_W'(0)}:  ch = 7'h48;
			{CNT_W'(2), SYM_W'(0)}:  ch = 7'h49;
			{CNT_W'(4), SYM_W'(14)}: ch = 7'h4A;
			{CNT_W'(3), SYM_W'(5)}:  ch = 7'h4B;
			{CNT_W'(4), SYM_W'(2)}:  ch = 7'h4C;
			{CNT_W'(2), SYM_W'(3)}:  ch = 7'h4D;
			{CNT_W'(2), SYM_W'(1)}:  ch = 7'h4E;
			{CNT_W'(3), SYM_W'(7)}:  ch = 7'h4F;
			{CNT_W'(4), SYM_W'(6)}:  ch = 7'h50;
			{CNT_W'(4), SYM_W'(11)}: ch = 7'h51;
			{CNT_W'(3), SYM_W'(2)}:  ch = 7'h52;
			{CNT_W'(3), SYM_W'(0)}:  ch = 7'h53;
			{CNT_W'(1), SYM_W'(1)}:  ch = 7'h54;
			{CNT_W'(3), SYM_W'(4)}:  ch = 7'h55;
			{CNT_W'(4), SYM_W'(8)}:  ch = 7'h56;
			{CNT_W'(3), SYM_W'(6)}:  ch = 7'h57;
			{CNT_W'(4), SYM_W'(9)}:  ch = 7'h58;
			{CNT_W'(4), SYM_W'(13)}: ch = 7'h59;
			{CNT_W'(4), SYM_W'(3)}:  ch = 7'h5A;
			{CNT_W'(5), SYM_W'(30)}: ch = 7'h31;
			{CNT_W'(5), SYM_W'(28)}: ch = 7'h32;
			{CNT_W'(5), SYM_W'(24)}: ch = 7'h33;
			{CNT_W'(5), SYM_W'(16)}: ch = 7'h34;
			{CNT_W'(5), SYM_W'(0)}:  ch = 7'h35;
			{CNT_W'(5), SYM_W'(1)}:  ch = 7'h36;
			{CNT_W'(5), SYM_W'(3)}:  ch = 7'h37;
			{CNT_W'(5), SYM_W'(7)}:  ch = 7'h38;
			{CNT_W'(5), SYM_W'(15)}: ch = 7'h39;
			{CNT_W'(5), SYM_W'(31)}: ch = 7'h30;
			default:                 ch = ASCII_NONE;
		endcase
		return ch;
	endfunction

endpackage

### hw/rtl/mtd_front.sv
// ----------------------------------------------------------------------------
// mtd_front
// Accepts edge and tick beats, measures periods, keeps the code buffer and
// queues one command for each beat that produces output.
// ----------------------------------------------------------------------------
module mtd_front
	import mtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [STAMP_W-1:0]   s_tdata,
	input  logic                 s_tuser,
	input  mtd_qstat_t           qstat,
	output logic                 push,
	output mtd_cmd_t             push_cmd
);

	logic [TICK_W-1:0]  dot_min_q, dot_max_q, dash_min_q, dash_max_q, gap_min_q;
	logic [STAMP_W-1:0] prev_q;
	logic [WRAP_W-1:0]  wrap_q;
	logic               press_q;
	logic [SYM_W-1:0]   bits_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               accept;
	logic               is_edge;
	logic [TICK_W-1:0]  period;
	logic               borrow;
	logic               is_dot, is_dash, is_gap;
	logic [SYM_W-1:0]   bits_app;
	logic [CNT_W-1:0]   cnt_app;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign is_edge  = !s_tuser;

	assign period = {wrap_q, s_tdata} - {{(TICK_W-STAMP_W){1'b0}}, prev_q};
	assign borrow = (wrap_q == '0) && (s_tdata < prev_q);

	assign is_dot  = press_q && !borrow && (period >= dot_min_q) && (period <= dot_max_q);
	assign is_dash = press_q && !borrow && !is_dot &&
		(period >= dash_min_q) && (period <= dash_max_q);
	assign is_gap  = !press_q && !borrow && (period >= gap_min_q);

	always_comb begin
		bits_app = bits_q;
		cnt_app  = cnt_q;
		if (cnt_q < CNT_W'(MAX_SYMBOLS)) begin
			if (is_dash) begin
				bits_app[cnt_q[SYM_IDX_W-1:0]] = 1'b1;
			end
			cnt_app = cnt_q + CNT_W'(1);
		end else begin
			cnt_app = CNT_W'(MAX_SYMBOLS + 1);
		end
	end

	assign push = accept && is_edge && (is_dot || is_dash || is_gap);

	always_comb begin
		push_cmd.cnt  = cnt_q;
		push_cmd.bits = bits_q;
		if (is_gap) begin
			push_cmd.cmd = CMD_GAP;
		end else if (is_dash) begin
			push_cmd.cmd = CMD_DASH;
		end else begin
			push_cmd.cmd = CMD_DOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_min_q  <= DOT_MIN_RST;
			dot_max_q  <= DOT_MAX_RST;
			dash_min_q <= DASH_MIN_RST;
			dash_max_q <= DASH_MAX_RST;
			gap_min_q  <= GAP_MIN_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_DOT_MIN:  dot_min_q  <= cfg_data;
				REG_DOT_MAX:  dot_max_q  <= cfg_data;
				REG_DASH_MIN: dash_min_q <= cfg_data;
				REG_DASH_MAX: dash_max_q <= cfg_data;
				REG_GAP_MIN:  gap_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			wrap_q  <= '0;
			press_q <= 1'b0;
			bits_q  <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (!is_edge) begin
				if (wrap_q != '1) begin
					wrap_q <= wrap_q + WRAP_W'(1);
				end
			end else begin
				prev_q  <= s_tdata;
				wrap_q  <= '0;
				press_q <= !press_q;
				if (is_dot || is_dash) begin
					bits_q <= bits_app;
					cnt_q  <= cnt_app;
				end else if (is_gap) begin
					bits_q <= '0;
					cnt_q  <= '0;
				end
			end
		end
	end

endmodule

### hw/rtl/mtd_queue.sv
// ----------------------------------------------------------------------------
// mtd_queue
// Small command FIFO between the front and back parts of the decoder.
// ----------------------------------------------------------------------------
module mtd_queue
	import mtd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mtd_cmd_t   push_cmd,
	input  logic       pop,
	output mtd_cmd_t   head,
	output mtd_qstat_t qstat
);

	mtd_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

### hw/rtl/mtd_back.sv
// ----------------------------------------------------------------------------
// mtd_back
// Turns queued commands into result beats: symbol echoes, spaces and
// decoded characters, held in an output register.
// ----------------------------------------------------------------------------
module mtd_back
	import mtd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mtd_cmd_t           head,
	input  mtd_qstat_t         qstat,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic [KIND_W-1:0]  m_tuser,
	output logic               m_tlast
);

	logic               valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [ASCII_W-1:0] ascii_q;
	logic               last_q;
	logic               pend_q;
	logic [ASCII_W-1:0] pend_ch_q;

	logic               load;
	logic [ASCII_W-1:0] ch;

	assign load = !valid_q || m_tready;
	assign pop  = load && !pend_q && !qstat.empty;
	assign ch   = mtd_lookup(head.cnt, head.bits);

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, ascii_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				kind_q  <= KIND_CHAR;
				ascii_q <= pend_ch_q;
				last_q  <= 1'b1;
			end else begin
				unique case (head.cmd)
					CMD_DOT: begin
						kind_q  <= KIND_DOT;
						ascii_q <= ASCII_DOT;
						last_q  <= 1'b1;
					end
					CMD_DASH: begin
						kind_q  <= KIND_DASH;
						ascii_q <= ASCII_DASH;
						last_q  <= 1'b1;
					end
					default: begin
						kind_q  <= KIND_SPACE;
						ascii_q <= ASCII_SPACE;
						last_q  <= (ch == ASCII_NONE);
					end
				endcase
			end
		end
		if (pop) begin
			pend_ch_q <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !qstat.empty;
				pend_q  <= !qstat.empty && (head.cmd == CMD_GAP) && (ch != ASCII_NONE);
			end
		end
	end

endmodule

### hw/rtl/morse_timing_decoder_unit.sv
// ----------------------------------------------------------------------------
// morse_timing_decoder_unit
// Morse key timing decoder: classifies key press and gap durations, echoes
// symbols and emits spaces and decoded characters.
//
// Channel  Dir  Signals                       Contents
// s_*      in   tvalid tready tdata tuser     tdata: stamp; tuser: op
// m_*      out  tvalid tready tdata tuser     tdata: ascii; tuser: kind;
//                tlast                         tlast: last result of an item
// cfg_*    in   wen index data                24-bit threshold registers
//
// An input beat is taken every cycle while the command queue has room; its
// period, classification and buffer update finish in that same cycle.
// Results leave through a registered output that the back part loads from
// the queue head; a gap with a known code takes two output beats.
// Reset is asynchronous, clears all control state and loads the default thresholds.
// An output stall fills the four-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module morse_timing_decoder_unit
	import mtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [STAMP_W-1:0]   s_tdata,   // [15:0] stamp
	input  logic                 s_tuser,   // [0] op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [6:0] ascii, [7] zero
	output logic [KIND_W-1:0]    m_tuser,   // [1:0] kind
	output logic                 m_tlast
);

	logic       push, pop;
	mtd_cmd_t   push_cmd, head;
	mtd_qstat_t qstat;

	mtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mtd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	mtd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
